### sv/slc_pkg.sv
`default_nettype none
package slc_pkg;

  // field widths fixed by the item format
  localparam int ADDR_W     = 64;
  localparam int KIND_W     = 2;
  localparam int OUTCOME_W  = 2;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // largest block offset width
  localparam int MAX_BLOCK_BITS = 16;

  // access kinds
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

  // outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [KIND_W-1:0] access_kind;
  } in_item_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic                 second_hit;
    logic [COUNT_W-1:0]   hit_count;
    logic [COUNT_W-1:0]   miss_count;
    logic [COUNT_W-1:0]   eviction_count;
  } out_item_t;

  // way selection result
  typedef struct packed {
    logic hit;
    logic evict;
  } sel_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage
`default_nettype wire

### sv/set_assoc_lru_cache_tags_top.sv
`default_nettype none
// channel  | signals                       | direction | moves
// ---------+-------------------------------+-----------+---------------------------
// in       | in_valid, in_stall, in_data   | to block  | access item (address, kind)
// out      | out_valid, out_stall, out_data| from block| outcome and running counts
// cfg      | cfg_we, cfg_idx, cfg_data     | to block  | set_bits, ways, block_bits
//
// each item takes a set-row read of the tag memory, then compare and write-back of the
// same row; the row memory has a registered read port, and no new item is taken meanwhile
// after reset a clearing pass zeroes all 2**MAX_SET_BITS rows (1024 by default) of the
// memory while in_stall stays high; configuration writes are taken during it
// a stalled result holds the block in lookup until the output register frees up
module set_assoc_lru_cache_tags_top #(
  parameter int MAX_SET_BITS = 10,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64,
  parameter int STAMP_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  slc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output slc_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [slc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [slc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import slc_pkg::*;

  localparam int TAG_W = ADDR_WIDTH - 2;
  localparam int ENT_W = 1 + TAG_W + STAMP_WIDTH;
  localparam int ROW_W = MAX_WAYS * ENT_W;
  localparam int NW_W  = $clog2(MAX_WAYS + 1);

  // configuration registers
  logic [3:0] set_bits_r;
  logic [3:0] ways_r;
  logic [4:0] block_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 4'd4;
      ways_r       <= 4'd1;
      block_bits_r <= 5'd4;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SET_BITS:   set_bits_r   <= cfg_data[3:0];
        CFG_WAYS:       ways_r       <= cfg_data[3:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp registers to their ranges
  logic [4:0]      sb_eff;
  logic [4:0]      bb_eff;
  logic [4:0]      nw_tmp;
  logic [NW_W-1:0] nw_eff;

  always_comb begin
    if (set_bits_r == '0) begin
      sb_eff = 5'd1;
    end else if ({1'b0, set_bits_r} > 5'(MAX_SET_BITS)) begin
      sb_eff = 5'(MAX_SET_BITS);
    end else begin
      sb_eff = {1'b0, set_bits_r};
    end
    if (block_bits_r == '0) begin
      bb_eff = 5'd1;
    end else if (block_bits_r > 5'(MAX_BLOCK_BITS)) begin
      bb_eff = 5'(MAX_BLOCK_BITS);
    end else begin
      bb_eff = block_bits_r;
    end
    if (ways_r == '0) begin
      nw_tmp = 5'd1;
    end else if ({1'b0, ways_r} > 5'(MAX_WAYS)) begin
      nw_tmp = 5'(MAX_WAYS);
    end else begin
      nw_tmp = {1'b0, ways_r};
    end
    nw_eff = NW_W'(nw_tmp);
  end

  // address split into tag and set index
  logic [ADDR_WIDTH-1:0]   addr_m;
  logic [5:0]              tag_shamt;
  logic [ADDR_WIDTH-1:0]   tag_full;
  logic [ADDR_WIDTH-1:0]   set_full;
  logic [MAX_SET_BITS:0]   set_one;
  logic [MAX_SET_BITS:0]   set_lsb_mask;
  logic [TAG_W-1:0]        tag_in;
  logic [MAX_SET_BITS-1:0] set_in;

  always_comb begin
    addr_m       = in_data.address[ADDR_WIDTH-1:0];
    tag_shamt    = 6'(sb_eff) + 6'(bb_eff);
    tag_full     = addr_m >> tag_shamt;
    set_full     = addr_m >> bb_eff;
    set_one      = (MAX_SET_BITS + 1)'(1) << sb_eff;
    set_lsb_mask = set_one - (MAX_SET_BITS + 1)'(1);
    tag_in       = tag_full[TAG_W-1:0];
    set_in       = set_full[MAX_SET_BITS-1:0] & set_lsb_mask[MAX_SET_BITS-1:0];
  end

  // control
  state_t                  state_r;
  state_t                  state_nxt;
  logic [MAX_SET_BITS-1:0] clr_cnt_r;
  logic                    out_valid_r;
  logic                    accept;
  logic                    load;
  logic                    clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    accept    = 1'b0;
    load      = 1'b0;
    clearing  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clearing = 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          accept    = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // item held across the lookup
  logic [TAG_W-1:0]        tag_q_r;
  logic [MAX_SET_BITS-1:0] set_q_r;
  logic [KIND_W-1:0]       kind_q_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_q_r  <= tag_in;
      set_q_r  <= set_in;
      kind_q_r <= in_data.access_kind;
    end
  end

  // set-row memory
  logic                    ram_we;
  logic [MAX_SET_BITS-1:0] ram_waddr;
  logic [ROW_W-1:0]        ram_wdata;
  logic [ROW_W-1:0]        rd_row;
  logic [ROW_W-1:0]        wr_row;

  assign ram_we    = clearing || load;
  assign ram_waddr = clearing ? clr_cnt_r : set_q_r;
  assign ram_wdata = clearing ? '0 : wr_row;

  slc_ram #(
    .ADDR_BITS (MAX_SET_BITS),
    .DATA_W    (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (set_in),
    .rdata (rd_row)
  );

  // hit, fill or victim way
  sel_t                sel;
  logic [MAX_WAYS-1:0] way_oh;

  slc_way_sel #(
    .WAYS    (MAX_WAYS),
    .TAG_W   (TAG_W),
    .STAMP_W (STAMP_WIDTH),
    .NW_W    (NW_W)
  ) u_way_sel (
    .row    (rd_row),
    .tag    (tag_q_r),
    .nw     (nw_eff),
    .sel    (sel),
    .way_oh (way_oh)
  );

  // access clock and running counts
  logic [STAMP_WIDTH-1:0] clock_r;
  logic [COUNT_W-1:0]     hit_cnt_r;
  logic [COUNT_W-1:0]     miss_cnt_r;
  logic [COUNT_W-1:0]     evict_cnt_r;
  logic [COUNT_W-1:0]     hit_cnt_nxt;
  logic [COUNT_W-1:0]     miss_cnt_nxt;
  logic [COUNT_W-1:0]     evict_cnt_nxt;
  logic                   is_modify;

  // selected way gets the tag and a fresh stamp
  always_comb begin
    wr_row = rd_row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (way_oh[w]) begin
        wr_row[w*ENT_W +: ENT_W] = {1'b1, tag_q_r, clock_r};
      end
    end
  end

  always_comb begin
    is_modify     = (kind_q_r == KIND_MODIFY);
    hit_cnt_nxt   = hit_cnt_r + COUNT_W'(sel.hit) + COUNT_W'(is_modify);
    miss_cnt_nxt  = miss_cnt_r + COUNT_W'(!sel.hit);
    evict_cnt_nxt = evict_cnt_r + COUNT_W'(sel.evict);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r     <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (load) begin
      clock_r     <= clock_r + 1'b1;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
    end
  end

  // output register
  out_item_t out_data_r;
  logic [OUTCOME_W-1:0] outcome_nxt;

  always_comb begin
    if (sel.hit) begin
      outcome_nxt = OUT_HIT;
    end else if (sel.evict) begin
      outcome_nxt = OUT_EVICT;
    end else begin
      outcome_nxt = OUT_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.outcome        <= outcome_nxt;
      out_data_r.second_hit     <= is_modify;
      out_data_r.hit_count      <= hit_cnt_nxt;
      out_data_r.miss_count     <= miss_cnt_nxt;
      out_data_r.eviction_count <= evict_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // exactly one way is picked for every lookup
  a_way_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOKUP |-> $onehot(way_oh))
    else $error("way select not one-hot");

  // a finished lookup leaves a result and returns to idle
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not presented after lookup");

  // a miss adds exactly one to the miss count
  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    load && !sel.hit |=> miss_cnt_r == $past(miss_cnt_r) + COUNT_W'(1))
    else $error("miss count out of step");

  // the access clock advances once per item
  a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> clock_r == $past(clock_r) + STAMP_WIDTH'(1))
    else $error("access clock out of step");

endmodule
`default_nettype wire

### sv/slc_ram.sv
`default_nettype none
module slc_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_W    = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_W-1:0]    wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_W-1:0]    rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_BITS];
  logic [DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### sv/slc_way_sel.sv
`default_nettype none
module slc_way_sel #(
  parameter int WAYS    = 8,
  parameter int TAG_W   = 62,
  parameter int STAMP_W = 32,
  parameter int NW_W    = 4
) (
  input  logic [WAYS*(1+TAG_W+STAMP_W)-1:0] row,
  input  logic [TAG_W-1:0]                  tag,
  input  logic [NW_W-1:0]                   nw,
  output slc_pkg::sel_t                     sel,
  output logic [WAYS-1:0]                   way_oh
);
  import slc_pkg::*;

  localparam int ENT_W = 1 + TAG_W + STAMP_W;

  // first matching way, else highest empty way, else oldest valid way
  always_comb begin
    logic               hit_found;
    logic               empty_found;
    logic               vic_found;
    logic [STAMP_W-1:0] vic_stamp;
    logic [WAYS-1:0]    hit_oh;
    logic [WAYS-1:0]    empty_oh;
    logic [WAYS-1:0]    vic_oh;
    logic               ent_valid;
    logic [TAG_W-1:0]   ent_tag;
    logic [STAMP_W-1:0] ent_stamp;
    hit_found   = 1'b0;
    empty_found = 1'b0;
    vic_found   = 1'b0;
    vic_stamp   = '0;
    hit_oh      = '0;
    empty_oh    = '0;
    vic_oh      = '0;
    for (int w = 0; w < WAYS; w++) begin
      ent_valid = row[w*ENT_W + ENT_W - 1];
      ent_tag   = row[w*ENT_W + STAMP_W +: TAG_W];
      ent_stamp = row[w*ENT_W +: STAMP_W];
      if ((NW_W'(w) < nw) && !hit_found) begin
        if (ent_valid && (ent_tag == tag)) begin
          hit_found = 1'b1;
          hit_oh    = '0;
          hit_oh[w] = 1'b1;
        end else if (!ent_valid) begin
          empty_found = 1'b1;
          empty_oh    = '0;
          empty_oh[w] = 1'b1;
        end else if (!vic_found || (ent_stamp < vic_stamp)) begin
          vic_found = 1'b1;
          vic_stamp = ent_stamp;
          vic_oh    = '0;
          vic_oh[w] = 1'b1;
        end
      end
    end
    sel.hit   = hit_found;
    sel.evict = !hit_found && !empty_found;
    if (hit_found) begin
      way_oh = hit_oh;
    end else if (empty_found) begin
      way_oh = empty_oh;
    end else begin
      way_oh = vic_oh;
    end
  end

endmodule
`default_nettype wire
